[rtl/tls_pkg.sv]
`default_nettype none
package tls_pkg;

	localparam int MAX_TILES = 64;
	localparam int CW = 7;      // tile count width
	localparam int SW = 14;     // span width
	localparam int PW = 17;     // position width
	localparam int IW = 6;      // tile index width

	localparam logic [1:0] MODE_ROWS = 2'd0;
	localparam logic [1:0] MODE_COLS = 2'd1;
	localparam logic [1:0] MODE_GRID = 2'd2;

	typedef struct packed {
		logic [13:0] area_x;
		logic [13:0] area_y;
		logic [13:0] area_width;
		logic [13:0] area_height;
		logic [6:0]  tile_count;
		logic [1:0]  layout_mode;
		logic [9:0]  gap_pixels;
	} tls_in_t;

	typedef struct packed {
		logic [5:0]  tile_index;
		logic [16:0] tile_x;
		logic [16:0] tile_y;
		logic [13:0] tile_width;
		logic [13:0] tile_height;
		logic        last_tile;
	} tls_out_t;

	// Divider request and reply between the sequencer and the shared unit.
	typedef struct packed {
		logic          start;
		logic [SW-1:0] dividend;
		logic [CW-1:0] divisor;
	} tls_div_req_t;

	typedef struct packed {
		logic          done;
		logic [SW-1:0] quot;
		logic [CW-1:0] rem;
	} tls_div_rsp_t;

endpackage
`default_nettype wire

[rtl/tls_divider.sv]
`default_nettype none
module tls_divider
	import tls_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire tls_div_req_t req,
	output tls_div_rsp_t      rsp
);

	// Restoring division, one quotient bit per cycle.
	logic [SW-1:0]   quot_q;
	logic [CW-1:0]   rem_q;
	logic [CW-1:0]   dvs_q;
	logic [3:0]      cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [CW:0]     trial;
	logic [CW:0]     diff;

	assign trial = {rem_q, quot_q[SW-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'(SW - 1);
				quot_q <= req.dividend;
				rem_q  <= '0;
				dvs_q  <= req.divisor;
			end else if (busy_q) begin
				if (!diff[CW]) begin
					rem_q  <= diff[CW-1:0];
					quot_q <= {quot_q[SW-2:0], 1'b1};
				end else begin
					rem_q  <= trial[CW-1:0];
					quot_q <= {quot_q[SW-2:0], 1'b0};
				end
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 4'd1;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
	assign rsp.rem  = rem_q;

endmodule
`default_nettype wire

[rtl/tile_layout_splitter_unit.sv]
`default_nettype none
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid/in_ready   | tls_in_t  (one layout request)
// out     | output    | out_valid/out_ready | tls_out_t (one tile rectangle)
//
// Rows and columns requests start the 14-step shared divider on the accepting
// cycle, wait for its done flag, then emit the tiles in order, one per cycle
// while the output does not stall. Grid requests add the column search (at
// most 8 columns), then the row search (at most 8 rows) and a second divider
// run. The bit-serial divider sets most of the request time.
// Reset clears the sequencer and the output valid; no data is cleared.
// A stalled output holds the current tile and the sequencer waits.
// A tile count of zero is consumed while idle and gives no beat.
module tile_layout_splitter_unit
	import tls_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire tls_in_t in_data,
	output logic         out_valid,
	input  wire logic    out_ready,
	output tls_out_t     out_data
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_SEARCH, ST_DIV1, ST_PREP2, ST_DIV2, ST_EMIT
	} state_t;

	state_t        state_q;
	tls_in_t       req_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] cols_q;
	logic [CW-1:0] rows_q;
	logic [SW-1:0] base_q;     // row/col size, or grid cell width
	logic [CW-1:0] rem_q;
	logic [SW-1:0] ch_q;       // grid cell height
	logic [CW-1:0] k_q;
	logic [CW-1:0] c_q;
	logic [CW-1:0] r_q;
	logic [PW-1:0] px_q;
	logic [PW-1:0] py_q;
	logic          grid_q;
	logic          colm_q;

	tls_div_req_t  dreq;
	tls_div_rsp_t  drsp;

	tls_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// Usable span: span - (cnt-1)*gap, floored at cnt. One narrow multiply.
	function automatic logic [SW-1:0] usable(input logic [SW-1:0] span,
			input logic [CW-1:0] cnt, input logic [9:0] gap);
		logic [17:0] g;
		logic [17:0] u;
		g = 18'(cnt - 7'd1) * 18'(gap);
		u = 18'(span) - g;
		if ($signed(u) < $signed(18'(cnt))) u = 18'(cnt);
		return u[SW-1:0];
	endfunction

	logic [13:0] sq;
	assign sq = 14'(cols_q) * 14'(cols_q);

	// Current tile geometry.
	logic [SW-1:0] sz;
	logic [17:0]   w_raw;
	logic [17:0]   h_raw;
	logic [SW-1:0] w_o;
	logic [SW-1:0] h_o;
	always_comb begin
		sz = base_q + ((k_q < rem_q) ? 14'd1 : 14'd0);
		if (grid_q) begin
			w_raw = (c_q == cols_q - 7'd1)
				? 18'(req_q.area_x) + 18'(req_q.area_width) - 18'(px_q) : 18'(base_q);
			h_raw = (r_q == rows_q - 7'd1)
				? 18'(req_q.area_y) + 18'(req_q.area_height) - 18'(py_q) : 18'(ch_q);
		end else if (colm_q) begin
			w_raw = 18'(sz);
			h_raw = 18'(req_q.area_height);
		end else begin
			w_raw = 18'(req_q.area_width);
			h_raw = 18'(sz);
		end
		w_o = ($signed(w_raw) < 18'sd1) ? 14'd1 : w_raw[SW-1:0];
		h_o = ($signed(h_raw) < 18'sd1) ? 14'd1 : h_raw[SW-1:0];
	end

	logic emit_go;
	assign emit_go = (state_q == ST_EMIT) && (!out_valid || out_ready);
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		dreq = '0;
		if (state_q == ST_SEARCH && !(sq < 14'(n_q))) begin
			dreq.start    = 1'b1;
			dreq.dividend = usable(req_q.area_width, cols_q, req_q.gap_pixels);
			dreq.divisor  = cols_q;
		end else if (state_q == ST_IDLE && in_valid && in_data.tile_count != '0) begin
			dreq.start    = in_data.layout_mode != MODE_GRID;
			dreq.dividend = usable(
				(in_data.layout_mode == MODE_COLS) ? in_data.area_width : in_data.area_height,
				(in_data.tile_count > 7'(MAX_TILES)) ? 7'(MAX_TILES) : in_data.tile_count,
				in_data.gap_pixels);
			dreq.divisor  = (in_data.tile_count > 7'(MAX_TILES)) ? 7'(MAX_TILES)
				: in_data.tile_count;
		end else if (state_q == ST_PREP2) begin
			dreq.start    = 1'b1;
			dreq.dividend = usable(req_q.area_height, rows_q, req_q.gap_pixels);
			dreq.divisor  = rows_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready && !emit_go) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && in_data.tile_count != '0) begin
						req_q  <= in_data;
						n_q    <= (in_data.tile_count > 7'(MAX_TILES)) ? 7'(MAX_TILES)
							: in_data.tile_count;
						grid_q <= in_data.layout_mode == MODE_GRID;
						colm_q <= in_data.layout_mode == MODE_COLS;
						cols_q <= 7'd1;
						state_q <= (in_data.layout_mode == MODE_GRID) ? ST_SEARCH : ST_DIV1;
					end
				end
				ST_SEARCH: begin
					if (sq < 14'(n_q)) cols_q <= cols_q + 7'd1;
					else state_q <= ST_DIV1;
				end
				ST_DIV1: begin
					if (drsp.done) begin
						base_q <= drsp.quot;
						if (grid_q) begin
							rem_q   <= '0;
							state_q <= ST_PREP2;
						end else begin
							rem_q   <= drsp.rem;
							state_q <= ST_EMIT;
						end
						k_q  <= '0;
						c_q  <= '0;
						r_q  <= '0;
						px_q <= 17'(req_q.area_x);
						py_q <= 17'(req_q.area_y);
					end
					// rows = ceil(n/cols): found by walking multiples, bounded by 8
					rows_q <= 7'd1;
				end
				ST_PREP2: begin
					if (14'(rows_q) * 14'(cols_q) < 14'(n_q)) rows_q <= rows_q + 7'd1;
					else state_q <= ST_DIV2;
				end
				ST_DIV2: begin
					if (drsp.done) begin
						ch_q    <= drsp.quot;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						out_valid           <= 1'b1;
						out_data.tile_index <= k_q[IW-1:0];
						out_data.tile_x     <= grid_q ? px_q : (colm_q ? px_q
							: 17'(req_q.area_x));
						out_data.tile_y     <= grid_q ? py_q : (colm_q ? 17'(req_q.area_y)
							: py_q);
						out_data.tile_width  <= w_o;
						out_data.tile_height <= h_o;
						out_data.last_tile   <= (k_q == n_q - 7'd1);
						k_q <= k_q + 7'd1;
						if (grid_q) begin
							if (c_q == cols_q - 7'd1) begin
								c_q  <= '0;
								r_q  <= r_q + 7'd1;
								px_q <= 17'(req_q.area_x);
								py_q <= py_q + 17'(ch_q) + 17'(req_q.gap_pixels);
							end else begin
								c_q  <= c_q + 7'd1;
								px_q <= px_q + 17'(base_q) + 17'(req_q.gap_pixels);
							end
						end else if (colm_q) begin
							px_q <= px_q + 17'(sz) + 17'(req_q.gap_pixels);
						end else begin
							py_q <= py_q + 17'(sz) + 17'(req_q.gap_pixels);
						end
						if (k_q == n_q - 7'd1) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// A new request is only ever taken while the sequencer is idle.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> state_q == ST_IDLE)
		else $error("accept outside idle");
	// The final tile returns the sequencer to idle.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_go && k_q == n_q - 7'd1) |=> state_q == ST_IDLE)
		else $error("last tile did not end request");
	// Tile index stays below the clamped count while emitting.
	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> k_q < n_q)
		else $error("tile index overran count");

endmodule
`default_nettype wire

[verif/tile_layout_checker.sv]
`default_nettype none
module tile_layout_checker
	import tls_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire logic     in_ready,
	input  wire tls_in_t  in_data,
	input  wire logic     out_valid,
	input  wire logic     out_ready,
	input  wire tls_out_t out_data,
	output int            mismatch_count,
	output int            tiles_pending,
	output int            tiles_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	tls_out_t expected_tiles[$];

	task automatic report_mismatch(input string what, input tls_out_t got,
			input tls_out_t want);
		$write("MISMATCH %s: got idx %0d x %0d y %0d w %0d h %0d last %0b, ",
			what, got.tile_index, got.tile_x, got.tile_y, got.tile_width,
			got.tile_height, got.last_tile);
		$display("want idx %0d x %0d y %0d w %0d h %0d last %0b",
			want.tile_index, want.tile_x, want.tile_y, want.tile_width,
			want.tile_height, want.last_tile);
		mismatch_count++;
	endtask

	function automatic tls_out_t make_tile(int k, int x, int y, int w, int h, bit last);
		tls_out_t t;
		if (w < 1) w = 1;
		if (h < 1) h = 1;
		t.tile_index = k[5:0];
		t.tile_x = x[16:0];
		t.tile_y = y[16:0];
		t.tile_width = w[13:0];
		t.tile_height = h[13:0];
		t.last_tile = last;
		return t;
	endfunction

	// Works out every tile rectangle of one layout request.
	task automatic predict_tiles(input tls_in_t req);
		int ax, ay, aw, ah, n, gap, cols, rows, uw, uh, cw, ch, k, x, y, w, h;
		int span, usable, base, rem, pos, s;
		bit colmode;
		ax = req.area_x;
		ay = req.area_y;
		aw = req.area_width;
		ah = req.area_height;
		n = req.tile_count;
		gap = req.gap_pixels;
		if (n == 0)
			return;
		if (n > MAX_TILES)
			n = MAX_TILES;
		if (req.layout_mode == MODE_GRID) begin
			cols = 1;
			while (cols * cols < n)
				cols++;
			rows = (n + cols - 1) / cols;
			uw = aw - (cols - 1) * gap;
			uh = ah - (rows - 1) * gap;
			if (uw < cols) uw = cols;
			if (uh < rows) uh = rows;
			cw = uw / cols;
			ch = uh / rows;
			k = 0;
			for (int r = 0; r < rows; r++) begin
				for (int c = 0; c < cols && k < n; c++) begin
					x = ax + c * (cw + gap);
					y = ay + r * (ch + gap);
					w = (c == cols - 1) ? (ax + aw - x) : cw;
					h = (r == rows - 1) ? (ay + ah - y) : ch;
					expected_tiles.push_back(make_tile(k, x, y, w, h, k == n - 1));
					k++;
				end
			end
		end else begin
			colmode = (req.layout_mode == MODE_COLS);
			span = colmode ? aw : ah;
			usable = span - (n - 1) * gap;
			if (usable < n)
				usable = n;
			base = usable / n;
			rem = usable % n;
			pos = colmode ? ax : ay;
			for (int i = 0; i < n; i++) begin
				s = base + ((i < rem) ? 1 : 0);
				if (colmode)
					expected_tiles.push_back(make_tile(i, pos, ay, s, ah, i == n - 1));
				else
					expected_tiles.push_back(make_tile(i, ax, pos, aw, s, i == n - 1));
				pos += s + gap;
			end
		end
	endtask

	always @(posedge clk) begin
		tls_out_t want;
		if (!arst_n) begin
			mismatch_count = 0;
			tiles_seen = 0;
			expected_tiles.delete();
		end else begin
			if (in_valid && in_ready)
				predict_tiles(in_data);
			if (out_valid && out_ready) begin
				tiles_seen++;
				if (expected_tiles.size() == 0) begin
					report_mismatch("unexpected beat", out_data, '0);
				end else begin
					want = expected_tiles.pop_front();
					if (out_data !== want)
						report_mismatch("field", out_data, want);
				end
			end
		end
		tiles_pending = expected_tiles.size();
	end
endmodule
`default_nettype wire

[verif/testbench.sv]
`default_nettype none
module testbench;
	import tls_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// The spare mode code, which the block must treat as rows.
	localparam logic [1:0] MODE_SPARE = 2'd3;
	// Cycles without any accepted beat before the run is declared hung.
	localparam int STALL_LIMIT = 4000;
	// Length of the deliberate output hold-off, long enough to fill the block.
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int RANDOM_REQUESTS = 180;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	tls_in_t  in_data;
	logic     out_valid;
	logic     out_ready;
	tls_out_t out_data;

	int mismatch_count;
	int tiles_pending;
	int tiles_seen;
	int requests_sent;
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_off_req;
	int quiet_cycles;

	tile_layout_splitter_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	tile_layout_checker checker_inst (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.mismatch_count(mismatch_count), .tiles_pending(tiles_pending),
		.tiles_seen(tiles_seen)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// The receiver either takes beats with a random stall rate, or, when a
	// hold-off is requested, keeps ready low for a long fixed stretch so that
	// the block backs up and stops accepting requests.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// The watchdog restarts its count whenever either channel moves a beat.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	function automatic tls_in_t layout_request(int x, int y, int w, int h, int n,
			logic [1:0] mode, int gap);
		tls_in_t req;
		req.area_x = x[13:0];
		req.area_y = y[13:0];
		req.area_width = w[13:0];
		req.area_height = h[13:0];
		req.tile_count = n[6:0];
		req.layout_mode = mode;
		req.gap_pixels = gap[9:0];
		return req;
	endfunction

	// Offers one request and holds it until the block accepts the beat. Valid
	// is only lowered when an idle cycle is actually inserted, so a back to
	// back request never sees valid dropped and raised in the same step.
	task automatic send_request(input tls_in_t req);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (!in_ready);
		requests_sent++;
	endtask

	// Random content, with tile counts mostly small so that the run stays short,
	// and now and then a full or saturating count.
	function automatic tls_in_t random_request();
		tls_in_t req;
		int pick;
		req = tls_in_t'({$urandom, $urandom, $urandom});
		pick = $urandom_range(99);
		if (pick < 5)
			req.tile_count = 7'd0;
		else if (pick < 80)
			req.tile_count = 7'($urandom_range(1, 9));
		else if (pick < 92)
			req.tile_count = 7'($urandom_range(10, 64));
		else
			req.tile_count = 7'($urandom_range(65, 127));
		// Small gaps most of the time so that the split is not always floored.
		if ($urandom_range(3) != 0)
			req.gap_pixels = 10'($urandom_range(0, 16));
		return req;
	endfunction

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		requests_sent = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_req = 1'b0;
		quiet_cycles = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: single tiles, full and saturated counts, every mode
		// including the spare one, area extremes, empty spans and large gaps.
		send_request(layout_request(0, 0, 1, 1, 1, MODE_ROWS, 0));
		send_request(layout_request(0, 0, 1, 1, 1, MODE_COLS, 0));
		send_request(layout_request(0, 0, 1, 1, 1, MODE_GRID, 0));
		send_request(layout_request(16383, 16383, 16383, 16383, 1, MODE_GRID, 1023));
		send_request(layout_request(100, 200, 1000, 777, 5, MODE_ROWS, 3));
		send_request(layout_request(100, 200, 1003, 600, 7, MODE_COLS, 2));
		send_request(layout_request(10, 20, 500, 400, 2, MODE_GRID, 5));
		send_request(layout_request(10, 20, 500, 400, 3, MODE_GRID, 5));
		send_request(layout_request(10, 20, 501, 403, 10, MODE_GRID, 4));
		send_request(layout_request(0, 0, 16383, 16383, 64, MODE_ROWS, 0));
		send_request(layout_request(0, 0, 16383, 16383, 64, MODE_COLS, 1));
		send_request(layout_request(16383, 16383, 16383, 16383, 64, MODE_GRID, 0));
		send_request(layout_request(5, 5, 300, 300, 127, MODE_ROWS, 2));
		send_request(layout_request(5, 5, 300, 300, 65, MODE_GRID, 1));
		send_request(layout_request(7, 9, 800, 90, 4, MODE_SPARE, 6));
		send_request(layout_request(1, 2, 50, 50, 0, MODE_GRID, 0));
		send_request(layout_request(3, 4, 0, 0, 3, MODE_ROWS, 0));
		send_request(layout_request(3, 4, 0, 0, 5, MODE_GRID, 2));
		send_request(layout_request(0, 0, 100, 100, 20, MODE_COLS, 1023));
		send_request(layout_request(0, 0, 100, 100, 9, MODE_GRID, 1023));
		send_request(layout_request(0, 0, 16383, 1, 64, MODE_ROWS, 1023));

		// Random part in four idling phases; the first also carries the long
		// receiver hold-off while requests keep coming.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  hold_off_req = 1'b1; end
				1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
				default: begin send_idle_pct = 36; recv_stall_pct = 36; end
			endcase
			for (int i = 0; i < RANDOM_REQUESTS / 4; i++)
				send_request(random_request());
		end
		in_valid <= 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;

		// Drain: the watchdog covers a block that never delivers.
		while (tiles_pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);

		$display("Covered %0d layout requests in rows, columns, grid and spare modes,",
			requests_sent);
		$display("%0d tile beats checked under four idling mixes and one long hold-off.",
			tiles_seen);
		if (mismatch_count == 0 && tiles_pending == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end
endmodule
`default_nettype wire

[tile_layout_splitter_unit.f]
rtl/tls_pkg.sv
rtl/tls_divider.sv
rtl/tile_layout_splitter_unit.sv
verif/tile_layout_checker.sv
verif/testbench.sv
